### hdl/vdp_host_port_assert.svh
// assertion macros shared by the host port rtl
`ifndef VDP_HOST_PORT_ASSERT_SVH
`define VDP_HOST_PORT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define VHP_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("host port check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define VHP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("host port check failed");

`endif

### hdl/vhp_pkg.sv
// shared types and constants of the video display processor host port
package vhp_pkg;

	// default video memory address width
	localparam int ADDR_BITS_DEF = 14;

	// number of display registers that accept a write
	localparam int REG_COUNT = 64;

	// access kinds
	localparam logic [2:0] KIND_DATA_READ   = 3'd0;
	localparam logic [2:0] KIND_STATUS_READ = 3'd1;
	localparam logic [2:0] KIND_CTRL_WRITE  = 3'd2;
	localparam logic [2:0] KIND_DATA_WRITE  = 3'd3;
	localparam logic [2:0] KIND_STATUS_PEEK = 3'd4;
	localparam logic [2:0] KIND_FRAME_TICK  = 3'd5;

	// one result transfer
	typedef struct packed {
		logic [7:0] read_byte;
		logic       reg_written;
		logic [5:0] reg_number;
		logic [7:0] reg_value;
		logic       frame_flag;
	} res_t;

endpackage

### hdl/vdp_host_port.sv
// Host port of the video display processor: one access in, one result out.
// Each result is registered in the output register, or in the skid entry
// while the output stalls. Throughput: one access per cycle while in_ready
// is high; each access does at most one video memory read or write, and
// results pass through a two-entry output buffer. Reset: control state
// clears at once; a sweep then zeroes every video memory byte, in_ready low.
`include "vdp_host_port_assert.svh"

module vdp_host_port #(
	parameter int ADDR_BITS = vhp_pkg::ADDR_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] kind,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_byte,
	output logic       reg_written,
	output logic [5:0] reg_number,
	output logic [7:0] reg_value,
	output logic       frame_flag
);
	import vhp_pkg::*;

	localparam int DEPTH = 1 << ADDR_BITS;

	// video memory and its registered read data
	logic [7:0]           mem [DEPTH];
	logic [7:0]           rdata_q;

	// port state
	logic [ADDR_BITS-1:0] addr_q;
	logic [7:0]           ra_q;
	logic                 ra_sel_q;
	logic                 pend_q;
	logic                 flag_q;

	// clearing sweep after reset
	logic                 clr_busy_q;
	logic [ADDR_BITS-1:0] clr_addr_q;

	// output buffer
	res_t                 out_q;
	logic                 out_v_q;
	res_t                 skid_q;
	logic                 skid_v_q;

	// next-state values of one access
	logic                 in_fire;
	logic                 out_fire;
	logic [7:0]           ra_cur;
	logic [ADDR_BITS-1:0] addr_set;
	logic [ADDR_BITS-1:0] addr_n;
	logic [7:0]           ra_n;
	logic                 ra_sel_n;
	logic                 pend_n;
	logic                 flag_n;
	logic                 acc_re;
	logic [ADDR_BITS-1:0] acc_raddr;
	logic                 acc_we;
	logic                 mem_we;
	logic [ADDR_BITS-1:0] mem_waddr;
	logic [7:0]           mem_wdata;
	res_t                 res_n;

	assign in_ready  = !skid_v_q && !clr_busy_q;
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_v_q && out_ready;
	assign ra_cur    = ra_sel_q ? rdata_q : ra_q;
	assign addr_set  = ADDR_BITS'({data_byte[5:0], addr_q[7:0]});

	// decode one access against the current state
	always_comb begin
		addr_n    = addr_q;
		ra_n      = ra_q;
		ra_sel_n  = ra_sel_q;
		pend_n    = pend_q;
		flag_n    = flag_q;
		acc_re    = 1'b0;
		acc_raddr = addr_q;
		acc_we    = 1'b0;
		res_n     = '0;
		case (kind)
			KIND_DATA_READ: begin
				res_n.read_byte = ra_cur;
				acc_re   = 1'b1;
				ra_sel_n = 1'b1;
				addr_n   = addr_q + 1'b1;
				pend_n   = 1'b0;
			end
			KIND_STATUS_READ: begin
				res_n.read_byte = {flag_q, 7'b0};
				flag_n = 1'b0;
				pend_n = 1'b0;
			end
			KIND_CTRL_WRITE: begin
				if (pend_q) begin
					addr_n = addr_set;
					if (data_byte[7] && ({1'b0, data_byte[5:0]} < 7'(REG_COUNT))) begin
						res_n.reg_written = 1'b1;
						res_n.reg_number  = data_byte[5:0];
						res_n.reg_value   = addr_q[7:0];
					end
					if (data_byte[7:6] == 2'b00) begin
						acc_re    = 1'b1;
						acc_raddr = addr_set;
						ra_sel_n  = 1'b1;
						addr_n    = addr_set + 1'b1;
					end
					pend_n = 1'b0;
				end else begin
					addr_n = {addr_q[ADDR_BITS-1:8], data_byte};
					pend_n = 1'b1;
				end
			end
			KIND_DATA_WRITE: begin
				acc_we   = 1'b1;
				ra_n     = data_byte;
				ra_sel_n = 1'b0;
				addr_n   = addr_q + 1'b1;
				pend_n   = 1'b0;
			end
			KIND_STATUS_PEEK: begin
				res_n.read_byte = {flag_q, 7'b0};
			end
			KIND_FRAME_TICK: begin
				flag_n = 1'b1;
			end
			default: begin
			end
		endcase
		res_n.frame_flag = flag_n;
	end

	// memory write port: clearing sweep or data write
	assign mem_we    = clr_busy_q || (in_fire && acc_we);
	assign mem_waddr = clr_busy_q ? clr_addr_q : addr_q;
	assign mem_wdata = clr_busy_q ? 8'h00 : data_byte;

	// video memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (in_fire && acc_re) begin
			rdata_q <= mem[acc_raddr];
		end
	end

	// read-ahead byte taken from a data write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ra_q <= 8'h00;
		end else if (in_fire) begin
			ra_q <= ra_n;
		end
	end

	// control state and clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q     <= '0;
			ra_sel_q   <= 1'b0;
			pend_q     <= 1'b0;
			flag_q     <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == '1) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (in_fire) begin
				addr_q   <= addr_n;
				ra_sel_q <= ra_sel_n;
				pend_q   <= pend_n;
				flag_q   <= flag_n;
			end
		end
	end

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || out_fire) begin
				out_v_q  <= skid_v_q || in_fire;
				skid_v_q <= 1'b0;
			end else if (in_fire) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	// output payloads
	always_ff @(posedge clk) begin
		if (!out_v_q || out_fire) begin
			out_q <= skid_v_q ? skid_q : res_n;
		end else if (in_fire) begin
			skid_q <= res_n;
		end
	end

	assign out_valid   = out_v_q;
	assign read_byte   = out_q.read_byte;
	assign reg_written = out_q.reg_written;
	assign reg_number  = out_q.reg_number;
	assign reg_value   = out_q.reg_value;
	assign frame_flag  = out_q.frame_flag;

	// checks
	`VHP_ASSERT_SAME(a_skid_behind_out, skid_v_q, out_v_q)
	`VHP_ASSERT_SAME(a_clear_full_sweep, $fell(clr_busy_q), $past(clr_addr_q) == '1)
	`VHP_ASSERT_NEXT(a_write_owns_ra, in_fire && (kind == KIND_DATA_WRITE), !ra_sel_q)
	`VHP_ASSERT_NEXT(a_first_byte_latch, in_fire && (kind == KIND_CTRL_WRITE) && !pend_q, pend_q)

endmodule
